### hdl/llff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package llff_pkg;

  // Width of the payload fields on both channels.
  localparam int unsigned DATA_W = 32;

  // Operation codes carried in the opcode field.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic              error;
    logic [DATA_W-1:0] data_out;
    logic              is_empty;
    logic              is_full;
  } rsp_t;

endpackage

`default_nettype wire

### hdl/linked_list_fifo_free_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Item
// req      in         req_valid / req_ready  llff_pkg::req_t (opcode, data_in)
// rsp      out        rsp_valid / rsp_ready  llff_pkg::rsp_t (error, data_out, is_empty, is_full)
//
// Each item is handled alone: the link and payload memories are read first, then
// the pointers are updated, the memories written back and the result register loaded.
// The item rate is set by that read-modify-write through the registered RAM read.
// After reset the block is ready at once; untouched entries are tracked by a fill
// count, so the link memory needs no clearing pass.
// While a result waits in the output register a new item is still accepted; it
// holds in its update step until the output register is free.

module linked_list_fifo_free_list #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output      logic           req_ready,
  input  wire llff_pkg::req_t req,
  output      logic           rsp_valid,
  input  wire logic           rsp_ready,
  output      llff_pkg::rsp_t rsp
);

  // Pointers carry one more value than the entries: DEPTH stands for null.
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // List pointers and the fill count. Entries at or above fresh_cnt have
  // never been allocated, so their link is still "next entry in order".
  logic [PW-1:0] head_ptr,  head_ptr_next;
  logic [PW-1:0] tail_ptr,  tail_ptr_next;
  logic [PW-1:0] free_head, free_head_next;
  logic [PW-1:0] fresh_cnt, fresh_cnt_next;

  // The item under work.
  logic              op_q;
  logic [DATA_WIDTH-1:0] data_q;

  // Memories: link per entry and payload per entry, both with registered reads.
  logic [PW-1:0]         link_mem    [DEPTH];
  logic [DATA_WIDTH-1:0] payload_mem [DEPTH];
  logic [PW-1:0]         link_rdata;
  logic [DATA_WIDTH-1:0] payload_rdata;

  logic          accept;
  logic          commit;
  logic [IW-1:0] link_raddr;
  logic [IW-1:0] payload_raddr;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic          payload_we;
  logic [IW-1:0] payload_waddr;

  logic          head_valid;
  logic          tail_valid;
  logic          free_valid;
  logic          free_fresh;
  logic [PW-1:0] free_link;
  logic [PW-1:0] deq_next;
  logic [63:0]   din_ext;
  logic [63:0]   dout_ext;
  llff_pkg::rsp_t rsp_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  assign head_valid = (head_ptr < NIL);
  assign tail_valid = (tail_ptr < NIL);
  assign free_valid = (free_head < NIL);

  // Read addresses are issued in the accept cycle from the current pointers.
  // A null pointer reads entry zero; that data is never used.
  always_comb begin
    link_raddr    = '0;
    payload_raddr = '0;
    if (head_valid) begin
      payload_raddr = head_ptr[IW-1:0];
    end
    if (req.opcode == llff_pkg::OP_DEQ) begin
      if (head_valid) begin
        link_raddr = head_ptr[IW-1:0];
      end
    end else begin
      if (free_valid) begin
        link_raddr = free_head[IW-1:0];
      end
    end
  end

  // Update step: work out the new pointers, the write-backs and the result.
  always_comb begin
    free_fresh = (free_head >= fresh_cnt);
    // A fresh entry still links to the next index; the last one links to null.
    free_link  = free_fresh ? (free_head + PW'(1)) : link_rdata;
    // The tail's link is taken as null, so a dequeue of the last entry ignores
    // the stored link, which may be stale or never written.
    deq_next   = (head_ptr == tail_ptr) ? NIL : link_rdata;
    din_ext    = 64'(data_q);
    dout_ext   = 64'(payload_rdata);

    head_ptr_next  = head_ptr;
    tail_ptr_next  = tail_ptr;
    free_head_next = free_head;
    fresh_cnt_next = fresh_cnt;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    payload_we     = 1'b0;
    payload_waddr  = free_head[IW-1:0];
    rsp_next.error    = 1'b0;
    rsp_next.data_out = '0;

    if (op_q == llff_pkg::OP_ENQ) begin
      if (!free_valid) begin
        rsp_next.error = 1'b1;
      end else begin
        free_head_next = free_link;
        if (free_fresh) begin
          fresh_cnt_next = fresh_cnt + PW'(1);
        end
        payload_we = 1'b1;
        // Hang the new entry after the current tail.
        if (tail_valid) begin
          link_we    = 1'b1;
          link_waddr = tail_ptr[IW-1:0];
          link_wdata = free_head;
        end
        tail_ptr_next = free_head;
        if (!head_valid) begin
          head_ptr_next = free_head;
        end
      end
    end else begin
      if (!head_valid) begin
        rsp_next.error = 1'b1;
      end else begin
        rsp_next.data_out = dout_ext[llff_pkg::DATA_W-1:0];
        head_ptr_next     = deq_next;
        if (deq_next >= NIL) begin
          head_ptr_next = NIL;
          tail_ptr_next = NIL;
        end
        // Push the freed entry onto the free list.
        link_we        = 1'b1;
        link_waddr     = head_ptr[IW-1:0];
        link_wdata     = free_head;
        free_head_next = head_ptr;
      end
    end

    rsp_next.is_empty = !(head_ptr_next < NIL);
    rsp_next.is_full  = !(free_head_next < NIL);
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we && commit) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (accept) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (payload_we && commit) begin
      payload_mem[payload_waddr] <= din_ext[DATA_WIDTH-1:0];
    end
    if (accept) begin
      payload_rdata <= payload_mem[payload_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.opcode;
      data_q <= DATA_WIDTH'({{(64 - llff_pkg::DATA_W){1'b0}}, req.data_in});
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      head_ptr  <= NIL;
      tail_ptr  <= NIL;
      free_head <= '0;
      fresh_cnt <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        rsp_valid <= 1'b1;
        head_ptr  <= head_ptr_next;
        tail_ptr  <= tail_ptr_next;
        free_head <= free_head_next;
        fresh_cnt <= fresh_cnt_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/llff_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module llff_sva (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire llff_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire llff_pkg::rsp_t rsp
);

  // A waiting result holds still until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed or vanished while stalled");

  // Only one item is at work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while one is at work");

  // With the output free, an accepted item yields its result after its read and update steps.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
    else $error("result did not appear after two cycles");

  // The list cannot be empty and have no free entry at once.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("empty and full flagged together");

  // A failed operation returns no data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error |-> rsp.data_out == '0)
    else $error("error result carries data");

endmodule

bind linked_list_fifo_free_list llff_sva u_llff_sva (.*);

`default_nettype wire

### sim/llff_checker.sv
`timescale 1ns / 1ps

module llff_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  llff_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  llff_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending,
  output int             full_hits,
  output int             empty_hits
);

  localparam int unsigned DW    = llff_pkg::DATA_W;
  localparam int unsigned PTR_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  // Shadow copy of the linked list and its free list.
  logic [PTR_W-1:0] link_mem [DEPTH];
  logic [DW-1:0]    word_mem [DEPTH];
  logic [PTR_W-1:0] free_ptr;
  logic [PTR_W-1:0] first_ptr;
  logic [PTR_W-1:0] last_ptr;

  llff_pkg::rsp_t awaited_rsp[$];
  int   mismatches;
  int   n_full;
  int   n_empty;

  task automatic clear_list();
    for (int i = 0; i < DEPTH; i++) begin
      link_mem[i] = PTR_W'(i + 1);
      word_mem[i] = '0;
    end
    free_ptr  = '0;
    first_ptr = NIL;
    last_ptr  = NIL;
  endtask

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic llff_pkg::rsp_t list_step(llff_pkg::req_t item);
    llff_pkg::rsp_t   r;
    logic [PTR_W-1:0] slot;
    r = '0;
    if (item.opcode == llff_pkg::OP_ENQ) begin
      if (free_ptr >= NIL) begin
        r.error = 1'b1;
      end else begin
        slot                       = free_ptr;
        free_ptr                   = link_mem[slot[IDX_W-1:0]];
        word_mem[slot[IDX_W-1:0]] = item.data_in;
        link_mem[slot[IDX_W-1:0]] = NIL;
        if (last_ptr < NIL) begin
          link_mem[last_ptr[IDX_W-1:0]] = slot;
        end
        last_ptr = slot;
        if (first_ptr >= NIL) begin
          first_ptr = slot;
        end
      end
    end else begin
      if (first_ptr >= NIL) begin
        r.error = 1'b1;
      end else begin
        slot       = first_ptr;
        r.data_out = word_mem[slot[IDX_W-1:0]];
        first_ptr  = link_mem[slot[IDX_W-1:0]];
        if (first_ptr >= NIL) begin
          first_ptr = NIL;
          last_ptr  = NIL;
        end
        link_mem[slot[IDX_W-1:0]] = free_ptr;
        free_ptr                   = slot;
      end
    end
    r.is_empty = (first_ptr >= NIL);
    r.is_full  = (free_ptr >= NIL);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    llff_pkg::rsp_t want;
    if (rst) begin
      clear_list();
      awaited_rsp.delete();
      mismatches = 0;
      n_full     = 0;
      n_empty    = 0;
    end else begin
      // A result can never belong to an item accepted at the same edge, so
      // checking before predicting keeps the order right.
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("Result 0x%0h arrived with no item outstanding.", rsp);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("error", DW'(want.error), DW'(rsp.error));
          compare_field("data_out", want.data_out, rsp.data_out);
          compare_field("is_empty", DW'(want.is_empty), DW'(rsp.is_empty));
          compare_field("is_full", DW'(want.is_full), DW'(rsp.is_full));
        end
      end
      if (req_valid && req_ready) begin
        want = list_step(req);
        awaited_rsp.push_back(want);
        if (want.error) begin
          if (req.opcode == llff_pkg::OP_ENQ) begin
            n_full++;
          end else begin
            n_empty++;
          end
        end
      end
    end
    pending    <= awaited_rsp.size();
    fail_count <= mismatches;
    full_hits  <= n_full;
    empty_hits <= n_empty;
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DW          = llff_pkg::DATA_W;
  // Number of random items after the directed opening.
  localparam int          RAND_ITEMS  = 1175;
  // Item index in the random part at which the receiver is told to hold off.
  localparam int          HOLD_AT     = 300;
  // Item index at which the sender stops until every result is back.
  localparam int          DRAIN_AT    = 700;
  localparam int          HOLD_CYCLES = 200;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  llff_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  llff_pkg::rsp_t rsp;

  int fail_count;
  int pending;
  int full_hits;
  int empty_hits;

  // Handshake between the sender and the receiver for the long hold-off.
  // The sender raises hold_rsp; the receiver raises hold_done when it is over.
  logic hold_rsp;
  logic hold_done;

  int n_enq;
  int n_deq;

  linked_list_fifo_free_list #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  llff_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .fail_count(fail_count),
    .pending(pending),
    .full_hits(full_hits),
    .empty_hits(empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run, so that the simulation stops when the block hangs.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Offers one item and returns at the edge where it is taken. The caller
  // decides whether valid drops afterwards, so valid is never lowered and
  // raised again in one time step.
  task automatic offer(input logic op, input logic [DW-1:0] word);
    llff_pkg::req_t item;
    item.opcode  = op;
    item.data_in = word;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (op == llff_pkg::OP_ENQ) begin
      n_enq++;
    end else begin
      n_deq++;
    end
  endtask

  // Drops valid for the given idle time; with n of zero the next item follows at once.
  task automatic idle_for(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Payloads lean on all zeros and all ones now and then so the extremes show
  // up in the random part as well.
  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: ready follows runs of different patterns (always ready, coin
  // flip, one cycle in three, mostly ready). Once the sender asks for it, ready
  // stays low for a long stretch so that the block backs up and stalls its input.
  initial begin
    int mode;
    int run_left;
    int phase;
    rsp_ready <= 1'b0;
    hold_done = 1'b0;
    run_left  = 0;
    phase     = 0;
    mode      = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp && !hold_done) begin
        rsp_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(8, 48);
        end
        run_left--;
        phase++;
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= (phase % 3 == 0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Sender, reset and verdict.
  initial begin
    int sent;
    int burst;
    int enq_pct;
    int waited;
    logic leftover;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    hold_rsp  = 1'b0;
    n_enq     = 0;
    n_deq     = 0;
    leftover  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening. A dequeue on the empty list must flag an error and
    // give zero even though data_in is all ones.
    offer(llff_pkg::OP_DEQ, '1);
    idle_for($urandom_range(0, 3));
    offer(llff_pkg::OP_ENQ, '0);
    offer(llff_pkg::OP_ENQ, '1);
    idle_for($urandom_range(0, 3));
    offer(llff_pkg::OP_DEQ, '0);
    offer(llff_pkg::OP_ENQ, 32'hA5A5_5A5A);
    offer(llff_pkg::OP_DEQ, '0);
    idle_for($urandom_range(0, 3));
    offer(llff_pkg::OP_DEQ, '1);
    offer(llff_pkg::OP_DEQ, '0);
    // Fill every entry with walking bit patterns, then push one more item into
    // the full store, which must come back as an error with the state kept.
    for (int i = 0; i < DEPTH; i++) begin
      if (i % 2 == 0) begin
        offer(llff_pkg::OP_ENQ, DW'(1) << (2 * i));
      end else begin
        offer(llff_pkg::OP_ENQ, ~(DW'(1) << (2 * i + 1)));
      end
      idle_for($urandom_range(0, 2));
    end
    offer(llff_pkg::OP_ENQ, 32'h1234_5678);

    // Random part. Each burst runs with a bias toward filling, draining or
    // a balanced mix, so the list swings between empty and full many times.
    sent    = 0;
    enq_pct = 50;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 16);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 80;
          1: enq_pct = 20;
          default: enq_pct = 50;
        endcase
      end
      for (int b = 0; b < burst && sent < RAND_ITEMS; b++) begin
        if (sent == HOLD_AT) begin
          hold_rsp = 1'b1;
        end
        if (sent == DRAIN_AT) begin
          // Pause until every result is back, then carry on.
          req_valid <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
        if ($urandom_range(1, 100) <= enq_pct) begin
          offer(llff_pkg::OP_ENQ, pick_word());
        end else begin
          offer(llff_pkg::OP_DEQ, pick_word());
        end
        sent++;
      end
      // No gaps while the receiver is held off, so the block backs up.
      if (hold_rsp && !hold_done) begin
        idle_for(0);
      end else if ($urandom_range(0, 3) == 0) begin
        idle_for(0);
      end else begin
        idle_for($urandom_range(1, 10));
      end
    end
    req_valid <= 1'b0;

    // Wait for the last results, then keep running to catch any extra one.
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 5000);
    if (pending != 0) begin
      $error("%0d results never arrived.", pending);
      leftover = 1'b1;
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d items: %0d enqueues and %0d dequeues.", n_enq + n_deq, n_enq,
             n_deq);
    $display("Enqueues refused on a full store: %0d; dequeues on an empty list: %0d.",
             full_hits, empty_hits);
    if (fail_count == 0 && !leftover) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/llff_pkg.sv
hdl/linked_list_fifo_free_list.sv
hdl/llff_checker.sv
sim/llff_checker.sv
sim/tb_top.sv
